>>> rtl/core/sca_pkg.sv
package sca_pkg;

    localparam int BLOCK_SHIFT = 15;
    localparam int NUM_BLOCKS  = 64;
    localparam int BLK_W       = 6;
    localparam int NUM_CLASSES = 32;
    localparam int CLS_W       = 6;
    localparam int CI_W        = 5;
    localparam int CHUNK_W     = 11;
    localparam int TOTAL_W     = 12;
    localparam int ADDR_W      = 21;
    localparam int SIZE_W      = 16;
    localparam int OFF_W       = 15;
    localparam int CNT_W       = 7;
    localparam int CRAM_AW     = BLK_W + CHUNK_W;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_BLOCKS = 1'd1;

    localparam logic [7:0] CLASS_WHOLE = 8'd254;
    localparam logic [7:0] CLASS_FREE  = 8'd255;

    localparam logic [1:0] MODE_PARTIAL = 2'd1;
    localparam logic [1:0] MODE_FULL    = 2'd2;
    localparam logic [1:0] MODE_EMPTY   = 2'd3;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_GET   = 2'd2,
        KIND_PUT   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_NO_BLOCK  = 2'd1,
        STAT_TOO_LARGE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_A_HEAD,
        S_A_POP,
        S_TAKE,
        S_TAKE_POP,
        S_THREAD,
        S_SETUP,
        S_GET_WR,
        S_F_CHK,
        S_F_DIV,
        S_F_UPD,
        S_P_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               we_class;
        logic               we_head;
        logic               we_cnt;
        logic               we_mode;
        logic               we_link;
        logic [BLK_W-1:0]   addr;
        logic [7:0]         cls;
        logic [CHUNK_W-1:0] head;
        logic [CHUNK_W-1:0] cnt;
        logic [1:0]         mode;
        logic [BLK_W-1:0]   link;
    } t_bt_wr;

    typedef struct packed {
        logic [7:0]         cls;
        logic [CHUNK_W-1:0] head;
        logic [CHUNK_W-1:0] cnt;
        logic [1:0]         mode;
        logic [BLK_W-1:0]   link;
    } t_bt_rd;

    typedef struct packed {
        logic             start;
        logic [OFF_W-1:0] dividend;
        logic [OFF_W-1:0] divisor;
    } t_div_ctl;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [OFF_W-1:0] quotient;
    } t_div_sts;

    function automatic logic [CLS_W-1:0] class_of_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W:0] e;
        logic [CLS_W-1:0] c;
        e = {1'b0, s};
        if (s <= 16'd128) begin
            c = CLS_W'((e + 17'd15 + ((s == 16'd0) ? 17'd1 : 17'd0)) >> 4);
        end else if (s <= 16'd256) begin
            c = CLS_W'(((e + 17'd31) >> 5) + 17'd4);
        end else if (s <= 16'd512) begin
            c = CLS_W'(((e + 17'd63) >> 6) + 17'd8);
        end else if (s <= 16'd1024) begin
            c = CLS_W'(((e + 17'd127) >> 7) + 17'd12);
        end else if (s <= 16'd2048) begin
            c = CLS_W'(((e + 17'd255) >> 8) + 17'd16);
        end else if (s <= 16'd4096) begin
            c = CLS_W'(((e + 17'd511) >> 9) + 17'd20);
        end else if (s <= 16'd6144) begin
            c = CLS_W'(((e + 17'd1023) >> 10) + 17'd24);
        end else if (s <= 16'd8192) begin
            c = CLS_W'(31);
        end else if (s <= 16'd16384) begin
            c = CLS_W'(32);
        end else begin
            c = '0;
        end
        return c;
    endfunction

    function automatic logic [OFF_W-1:0] class_bytes(input logic [CI_W-1:0] ci);
        logic [OFF_W-1:0] r;
        unique case (ci)
            5'd0:  r = 15'd16;
            5'd1:  r = 15'd32;
            5'd2:  r = 15'd48;
            5'd3:  r = 15'd64;
            5'd4:  r = 15'd80;
            5'd5:  r = 15'd96;
            5'd6:  r = 15'd112;
            5'd7:  r = 15'd128;
            5'd8:  r = 15'd160;
            5'd9:  r = 15'd192;
            5'd10: r = 15'd224;
            5'd11: r = 15'd256;
            5'd12: r = 15'd320;
            5'd13: r = 15'd384;
            5'd14: r = 15'd448;
            5'd15: r = 15'd512;
            5'd16: r = 15'd640;
            5'd17: r = 15'd768;
            5'd18: r = 15'd896;
            5'd19: r = 15'd1024;
            5'd20: r = 15'd1280;
            5'd21: r = 15'd1536;
            5'd22: r = 15'd1792;
            5'd23: r = 15'd2048;
            5'd24: r = 15'd2560;
            5'd25: r = 15'd3072;
            5'd26: r = 15'd3584;
            5'd27: r = 15'd4096;
            5'd28: r = 15'd5120;
            5'd29: r = 15'd6144;
            5'd30: r = 15'd8192;
            default: r = 15'd16384;
        endcase
        return r;
    endfunction

    function automatic logic [TOTAL_W-1:0] class_chunks(input logic [CI_W-1:0] ci);
        logic [TOTAL_W-1:0] r;
        unique case (ci)
            5'd0:  r = 12'd2048;
            5'd1:  r = 12'd1024;
            5'd2:  r = 12'd682;
            5'd3:  r = 12'd512;
            5'd4:  r = 12'd409;
            5'd5:  r = 12'd341;
            5'd6:  r = 12'd292;
            5'd7:  r = 12'd256;
            5'd8:  r = 12'd204;
            5'd9:  r = 12'd170;
            5'd10: r = 12'd146;
            5'd11: r = 12'd128;
            5'd12: r = 12'd102;
            5'd13: r = 12'd85;
            5'd14: r = 12'd73;
            5'd15: r = 12'd64;
            5'd16: r = 12'd51;
            5'd17: r = 12'd42;
            5'd18: r = 12'd36;
            5'd19: r = 12'd32;
            5'd20: r = 12'd25;
            5'd21: r = 12'd21;
            5'd22: r = 12'd18;
            5'd23: r = 12'd16;
            5'd24: r = 12'd12;
            5'd25: r = 12'd10;
            5'd26: r = 12'd9;
            5'd27: r = 12'd8;
            5'd28: r = 12'd6;
            5'd29: r = 12'd5;
            5'd30: r = 12'd4;
            default: r = 12'd2;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/sca_req_if.sv
interface sca_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     kind;
    logic [sca_pkg::SIZE_W-1:0]     request_size;
    logic [sca_pkg::ADDR_W-1:0]     chunk_address;
    logic [sca_pkg::BLK_W-1:0]      put_block;

    modport source (output valid, kind, request_size, chunk_address, put_block, input ready);
    modport sink   (input valid, kind, request_size, chunk_address, put_block, output ready);
endinterface

>>> rtl/core/sca_rsp_if.sv
interface sca_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [sca_pkg::ADDR_W-1:0]     granted_address;
    logic [sca_pkg::BLK_W-1:0]      granted_block;
    logic [1:0]                     status;

    modport source (output valid, granted_address, granted_block, status, input ready);
    modport sink   (input valid, granted_address, granted_block, status, output ready);
endinterface

>>> rtl/core/sca_divider.sv
module sca_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sca_pkg::t_div_ctl i_ctl,
    output sca_pkg::t_div_sts o_sts
);

    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    logic [3:0]                 r_step, n_step;
    logic [sca_pkg::OFF_W-1:0]  r_rem, n_rem;
    logic [sca_pkg::OFF_W-1:0]  r_quo, n_quo;
    logic [sca_pkg::OFF_W-1:0]  r_dvs, n_dvs;
    logic [sca_pkg::OFF_W:0]    sh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        sh     = {r_rem, r_quo[sca_pkg::OFF_W-1]};
        if (i_ctl.start && !r_busy) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = '0;
            n_quo  = i_ctl.dividend;
            n_dvs  = i_ctl.divisor;
        end else if (r_busy) begin
            if (sh >= {1'b0, r_dvs}) begin
                n_rem = sca_pkg::OFF_W'(sh - {1'b0, r_dvs});
                n_quo = {r_quo[sca_pkg::OFF_W-2:0], 1'b1};
            end else begin
                n_rem = sh[sca_pkg::OFF_W-1:0];
                n_quo = {r_quo[sca_pkg::OFF_W-2:0], 1'b0};
            end
            if (r_step == 4'(sca_pkg::OFF_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_step = r_step + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_sts.busy     = r_busy;
    assign o_sts.done     = r_done;
    assign o_sts.quotient = r_quo;

endmodule

>>> rtl/core/sca_chunk_ram.sv
module sca_chunk_ram (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [sca_pkg::CRAM_AW-1:0]  i_waddr,
    input  logic [sca_pkg::CHUNK_W-1:0]  i_wdata,
    input  logic [sca_pkg::CRAM_AW-1:0]  i_raddr,
    output logic [sca_pkg::CHUNK_W-1:0]  o_rdata
);

    logic [sca_pkg::CHUNK_W-1:0] mem [2**sca_pkg::CRAM_AW];
    logic [sca_pkg::CHUNK_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/sca_block_table.sv
module sca_block_table (
    input  logic                       i_clk,
    input  sca_pkg::t_bt_wr            i_wr,
    input  logic [sca_pkg::BLK_W-1:0]  i_raddr,
    output sca_pkg::t_bt_rd            o_rd
);

    logic [7:0]                  mem_cls  [sca_pkg::NUM_BLOCKS];
    logic [sca_pkg::CHUNK_W-1:0] mem_head [sca_pkg::NUM_BLOCKS];
    logic [sca_pkg::CHUNK_W-1:0] mem_cnt  [sca_pkg::NUM_BLOCKS];
    logic [1:0]                  mem_mode [sca_pkg::NUM_BLOCKS];
    logic [sca_pkg::BLK_W-1:0]   mem_link [sca_pkg::NUM_BLOCKS];
    sca_pkg::t_bt_rd             r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.we_class) mem_cls[i_wr.addr]  <= i_wr.cls;
        if (i_wr.we_head)  mem_head[i_wr.addr] <= i_wr.head;
        if (i_wr.we_cnt)   mem_cnt[i_wr.addr]  <= i_wr.cnt;
        if (i_wr.we_mode)  mem_mode[i_wr.addr] <= i_wr.mode;
        if (i_wr.we_link)  mem_link[i_wr.addr] <= i_wr.link;
        r_rd.cls  <= mem_cls[i_raddr];
        r_rd.head <= mem_head[i_raddr];
        r_rd.cnt  <= mem_cnt[i_raddr];
        r_rd.mode <= mem_mode[i_raddr];
        r_rd.link <= mem_link[i_raddr];
    end

    assign o_rd = r_rd;

endmodule

>>> rtl/core/slab_chunk_allocator.sv
// Slab allocator with 32 size classes over 64 blocks of 32 KiB. One request is
// taken at a time; ready is high only while the sequencer is idle, and a finished
// result sits in an output register so the next request may start before it is
// taken. An oversized alloc, or a free or put naming a block out of range, ends
// at decode; a put or free first reads its block's table entry, and a free that
// passes that check runs the 15-step restoring divider to find the chunk index.
// An alloc is served from a partial block of its class when one exists; else it,
// like a get, takes a block off the free stack or from the bump pointer and fails
// when neither has one. Opening a fresh block for an alloc threads its chunk list
// one link per cycle through the single write port of the chunk link memory.
// While a result waits untaken in the output register, the next request holds
// in its last cycle.
module slab_chunk_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sca_req_if.sink                         i_req,
    sca_rsp_if.source                       o_rsp,
    input  logic                            i_cfg_we,
    input  logic [sca_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sca_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int BW = sca_pkg::BLK_W;
    localparam int CW = sca_pkg::CHUNK_W;

    sca_pkg::t_state          r_state, n_state;
    sca_pkg::t_kind           r_kind, n_kind;
    logic [sca_pkg::SIZE_W-1:0] r_size, n_size;
    logic [sca_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [BW-1:0]            r_put, n_put;
    logic [sca_pkg::CNT_W-1:0] r_total_cfg;
    logic [BW-1:0]            r_res_cfg;
    logic [BW-1:0]            r_top, n_top;
    logic [sca_pkg::CNT_W-1:0] r_next, n_next;
    logic [sca_pkg::NUM_BLOCKS-1:0] r_map [sca_pkg::NUM_CLASSES];
    logic [sca_pkg::CLS_W-1:0] r_cls, n_cls;
    logic [sca_pkg::CI_W-1:0] r_ci, n_ci;
    logic [BW-1:0]            r_blk, n_blk;
    logic [CW-1:0]            r_head, n_head;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic [1:0]               r_mode, n_mode;
    logic [CW-1:0]            r_idx, n_idx;
    logic [sca_pkg::TOTAL_W-1:0] r_total, n_total;
    logic [sca_pkg::OFF_W-1:0] r_bytes, n_bytes;
    logic [sca_pkg::OFF_W-1:0] r_chunk, n_chunk;
    logic [sca_pkg::ADDR_W-1:0] r_res_addr, n_res_addr;
    logic [BW-1:0]            r_res_blk, n_res_blk;
    sca_pkg::t_status         r_res_stat, n_res_stat;
    logic                     r_rsp_valid, n_rsp_valid;
    logic [sca_pkg::ADDR_W-1:0] r_rsp_addr, n_rsp_addr;
    logic [BW-1:0]            r_rsp_blk, n_rsp_blk;
    sca_pkg::t_status         r_rsp_stat, n_rsp_stat;

    sca_pkg::t_bt_wr          bt_wr;
    sca_pkg::t_bt_rd          bt_rd;
    logic [BW-1:0]            bt_raddr;
    logic                     ck_we;
    logic [sca_pkg::CRAM_AW-1:0] ck_waddr, ck_raddr;
    logic [CW-1:0]            ck_wdata, ck_rdata;
    sca_pkg::t_div_ctl        div_ctl;
    sca_pkg::t_div_sts        div_sts;
    logic                     map_we, map_on;
    logic [sca_pkg::CI_W-1:0] map_ci;
    logic [BW-1:0]            map_b;

    logic [sca_pkg::CNT_W-1:0] arena;
    logic [sca_pkg::CLS_W-1:0] dec_cls;
    logic [sca_pkg::CI_W-1:0]  dec_ci;
    logic [sca_pkg::CI_W-1:0]  chk_ci;
    logic [sca_pkg::CNT_W-1:0] bump;
    logic [sca_pkg::NUM_BLOCKS-1:0] scan_word;
    logic [BW-1:0]            scan_blk;
    logic [25:0]              prod;
    logic                     req_accept;

    function automatic logic in_range(input logic [BW-1:0] b,
                                      input logic [BW-1:0] res,
                                      input logic [sca_pkg::CNT_W-1:0] ar,
                                      input logic [sca_pkg::CNT_W-1:0] nx);
        logic [sca_pkg::CNT_W-1:0] e;
        e = {1'b0, b};
        return (b >= res) && (e < ar) && (e < nx) && (b != '0);
    endfunction

    function automatic logic [BW-1:0] first_set(input logic [sca_pkg::NUM_BLOCKS-1:0] m);
        logic [BW-1:0] r;
        r = '0;
        for (int i = sca_pkg::NUM_BLOCKS - 1; i >= 0; i--) begin
            if (m[i]) r = BW'(i);
        end
        return r;
    endfunction

    sca_block_table u_block_table (
        .i_clk   (i_clk),
        .i_wr    (bt_wr),
        .i_raddr (bt_raddr),
        .o_rd    (bt_rd)
    );

    sca_chunk_ram u_chunk_ram (
        .i_clk   (i_clk),
        .i_we    (ck_we),
        .i_waddr (ck_waddr),
        .i_wdata (ck_wdata),
        .i_raddr (ck_raddr),
        .o_rdata (ck_rdata)
    );

    sca_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .o_sts   (div_sts)
    );

    assign arena     = (r_total_cfg > 7'(sca_pkg::NUM_BLOCKS)) ? 7'(sca_pkg::NUM_BLOCKS)
                                                               : r_total_cfg;
    assign dec_cls   = sca_pkg::class_of_size(r_size);
    assign dec_ci    = sca_pkg::CI_W'(dec_cls - 6'd1);
    assign chk_ci    = sca_pkg::CI_W'(bt_rd.cls - 8'd1);
    assign bump      = (r_next < {1'b0, r_res_cfg}) ? {1'b0, r_res_cfg} : r_next;
    assign scan_word = r_map[r_ci];
    assign scan_blk  = first_set(scan_word);
    assign prod      = 26'(r_head) * 26'(r_bytes);
    assign req_accept = i_req.valid && i_req.ready;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_size      = r_size;
        n_addr      = r_addr;
        n_put       = r_put;
        n_top       = r_top;
        n_next      = r_next;
        n_cls       = r_cls;
        n_ci        = r_ci;
        n_blk       = r_blk;
        n_head      = r_head;
        n_cnt       = r_cnt;
        n_mode      = r_mode;
        n_idx       = r_idx;
        n_total     = r_total;
        n_bytes     = r_bytes;
        n_chunk     = r_chunk;
        n_res_addr  = r_res_addr;
        n_res_blk   = r_res_blk;
        n_res_stat  = r_res_stat;
        n_rsp_valid = r_rsp_valid && !o_rsp.ready;
        n_rsp_addr  = r_rsp_addr;
        n_rsp_blk   = r_rsp_blk;
        n_rsp_stat  = r_rsp_stat;
        i_req.ready = 1'b0;
        bt_wr       = '0;
        bt_raddr    = r_blk;
        ck_we       = 1'b0;
        ck_waddr    = {r_blk, r_idx};
        ck_wdata    = '0;
        ck_raddr    = {r_blk, bt_rd.head};
        div_ctl     = '0;
        map_we      = 1'b0;
        map_on      = 1'b0;
        map_ci      = r_ci;
        map_b       = r_blk;

        unique case (r_state)
            sca_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_kind  = sca_pkg::t_kind'(i_req.kind);
                    n_size  = i_req.request_size;
                    n_addr  = i_req.chunk_address;
                    n_put   = i_req.put_block;
                    n_state = sca_pkg::S_DECODE;
                end
            end
            sca_pkg::S_DECODE: begin
                n_res_addr = '0;
                n_res_blk  = '0;
                n_res_stat = sca_pkg::STAT_DONE;
                n_state    = sca_pkg::S_DONE;
                unique case (r_kind)
                    sca_pkg::KIND_ALLOC: begin
                        n_cls   = dec_cls;
                        n_ci    = dec_ci;
                        n_bytes = sca_pkg::class_bytes(dec_ci);
                        n_total = sca_pkg::class_chunks(dec_ci);
                        if (dec_cls == '0) begin
                            n_res_stat = sca_pkg::STAT_TOO_LARGE;
                        end else begin
                            n_state = sca_pkg::S_SCAN;
                        end
                    end
                    sca_pkg::KIND_FREE: begin
                        n_blk    = r_addr[sca_pkg::ADDR_W-1:sca_pkg::BLOCK_SHIFT];
                        bt_raddr = r_addr[sca_pkg::ADDR_W-1:sca_pkg::BLOCK_SHIFT];
                        if (in_range(r_addr[sca_pkg::ADDR_W-1:sca_pkg::BLOCK_SHIFT],
                                     r_res_cfg, arena, r_next)) begin
                            n_state = sca_pkg::S_F_CHK;
                        end
                    end
                    sca_pkg::KIND_GET: begin
                        n_state = sca_pkg::S_TAKE;
                    end
                    sca_pkg::KIND_PUT: begin
                        n_blk    = r_put;
                        bt_raddr = r_put;
                        if (in_range(r_put, r_res_cfg, arena, r_next)) begin
                            n_state = sca_pkg::S_P_CHK;
                        end
                    end
                    default: begin
                        n_state = sca_pkg::S_DONE;
                    end
                endcase
            end
            sca_pkg::S_SCAN: begin
                bt_raddr = scan_blk;
                n_blk    = scan_blk;
                if (scan_word != '0) begin
                    n_state = sca_pkg::S_A_HEAD;
                end else begin
                    n_state = sca_pkg::S_TAKE;
                end
            end
            sca_pkg::S_A_HEAD: begin
                n_head   = bt_rd.head;
                n_cnt    = bt_rd.cnt;
                ck_raddr = {r_blk, bt_rd.head};
                n_state  = sca_pkg::S_A_POP;
            end
            sca_pkg::S_A_POP: begin
                bt_wr.addr   = r_blk;
                bt_wr.we_cnt = 1'b1;
                if (r_cnt > 11'd1) begin
                    bt_wr.cnt     = r_cnt - 11'd1;
                    bt_wr.we_head = 1'b1;
                    bt_wr.head    = ck_rdata;
                end else begin
                    bt_wr.cnt     = '0;
                    bt_wr.we_mode = 1'b1;
                    bt_wr.mode    = sca_pkg::MODE_FULL;
                    map_we        = 1'b1;
                end
                n_res_addr = {r_blk, 15'd0} + prod[sca_pkg::ADDR_W-1:0];
                n_state    = sca_pkg::S_DONE;
            end
            sca_pkg::S_TAKE: begin
                bt_raddr = r_top;
                n_idx    = 11'd1;
                if (r_top != '0) begin
                    n_state = sca_pkg::S_TAKE_POP;
                end else if (bump >= arena) begin
                    n_res_stat = sca_pkg::STAT_NO_BLOCK;
                    n_state    = sca_pkg::S_DONE;
                end else begin
                    n_next  = bump + 7'd1;
                    n_blk   = bump[BW-1:0];
                    n_state = (r_kind == sca_pkg::KIND_ALLOC) ? sca_pkg::S_THREAD
                                                              : sca_pkg::S_GET_WR;
                end
            end
            sca_pkg::S_TAKE_POP: begin
                n_blk   = r_top;
                n_top   = bt_rd.link;
                n_state = (r_kind == sca_pkg::KIND_ALLOC) ? sca_pkg::S_THREAD
                                                          : sca_pkg::S_GET_WR;
            end
            sca_pkg::S_THREAD: begin
                ck_we    = 1'b1;
                ck_waddr = {r_blk, r_idx};
                if (r_idx == CW'(r_total - 12'd1)) begin
                    ck_wdata = '0;
                    n_state  = sca_pkg::S_SETUP;
                end else begin
                    ck_wdata = r_idx + 11'd1;
                    n_idx    = r_idx + 11'd1;
                end
            end
            sca_pkg::S_SETUP: begin
                bt_wr.addr     = r_blk;
                bt_wr.we_class = 1'b1;
                bt_wr.cls      = 8'(r_cls);
                bt_wr.we_mode  = 1'b1;
                bt_wr.mode     = sca_pkg::MODE_PARTIAL;
                bt_wr.we_cnt   = 1'b1;
                bt_wr.cnt      = CW'(r_total - 12'd1);
                bt_wr.we_head  = 1'b1;
                bt_wr.head     = 11'd1;
                map_we         = 1'b1;
                map_on         = 1'b1;
                n_res_addr     = {r_blk, 15'd0};
                n_state        = sca_pkg::S_DONE;
            end
            sca_pkg::S_GET_WR: begin
                bt_wr.addr     = r_blk;
                bt_wr.we_class = 1'b1;
                bt_wr.cls      = sca_pkg::CLASS_WHOLE;
                n_res_blk      = r_blk;
                n_state        = sca_pkg::S_DONE;
            end
            sca_pkg::S_F_CHK: begin
                n_ci    = chk_ci;
                n_bytes = sca_pkg::class_bytes(chk_ci);
                n_total = sca_pkg::class_chunks(chk_ci);
                n_head  = bt_rd.head;
                n_cnt   = bt_rd.cnt;
                n_mode  = bt_rd.mode;
                if ((bt_rd.cls >= 8'd1) && (bt_rd.cls <= 8'(sca_pkg::NUM_CLASSES)) &&
                    ((bt_rd.mode == sca_pkg::MODE_PARTIAL) ||
                     (bt_rd.mode == sca_pkg::MODE_FULL))) begin
                    div_ctl.start    = 1'b1;
                    div_ctl.dividend = r_addr[sca_pkg::OFF_W-1:0];
                    div_ctl.divisor  = sca_pkg::class_bytes(chk_ci);
                    n_state          = sca_pkg::S_F_DIV;
                end else begin
                    n_state = sca_pkg::S_DONE;
                end
            end
            sca_pkg::S_F_DIV: begin
                if (div_sts.done) begin
                    n_chunk = div_sts.quotient;
                    n_state = sca_pkg::S_F_UPD;
                end
            end
            sca_pkg::S_F_UPD: begin
                n_state    = sca_pkg::S_DONE;
                bt_wr.addr = r_blk;
                ck_waddr   = {r_blk, r_chunk[CW-1:0]};
                if (r_chunk >= sca_pkg::OFF_W'(r_total)) begin
                    n_state = sca_pkg::S_DONE;
                end else if (r_mode == sca_pkg::MODE_FULL) begin
                    ck_we         = 1'b1;
                    ck_wdata      = '0;
                    bt_wr.we_head = 1'b1;
                    bt_wr.head    = r_chunk[CW-1:0];
                    bt_wr.we_cnt  = 1'b1;
                    bt_wr.cnt     = 11'd1;
                    bt_wr.we_mode = 1'b1;
                    bt_wr.mode    = sca_pkg::MODE_PARTIAL;
                    map_we        = 1'b1;
                    map_on        = 1'b1;
                end else if ((12'(r_cnt) + 12'd1) >= r_total) begin
                    bt_wr.we_cnt   = 1'b1;
                    bt_wr.cnt      = '0;
                    bt_wr.we_mode  = 1'b1;
                    bt_wr.mode     = sca_pkg::MODE_EMPTY;
                    bt_wr.we_class = 1'b1;
                    bt_wr.cls      = sca_pkg::CLASS_FREE;
                    bt_wr.we_link  = 1'b1;
                    bt_wr.link     = r_top;
                    n_top          = r_blk;
                    map_we         = 1'b1;
                end else begin
                    ck_we         = 1'b1;
                    ck_wdata      = r_head;
                    bt_wr.we_head = 1'b1;
                    bt_wr.head    = r_chunk[CW-1:0];
                    bt_wr.we_cnt  = 1'b1;
                    bt_wr.cnt     = r_cnt + 11'd1;
                end
            end
            sca_pkg::S_P_CHK: begin
                if (bt_rd.cls == sca_pkg::CLASS_WHOLE) begin
                    bt_wr.addr     = r_blk;
                    bt_wr.we_class = 1'b1;
                    bt_wr.cls      = sca_pkg::CLASS_FREE;
                    bt_wr.we_link  = 1'b1;
                    bt_wr.link     = r_top;
                    n_top          = r_blk;
                end
                n_state = sca_pkg::S_DONE;
            end
            sca_pkg::S_DONE: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_rsp_valid = 1'b1;
                    n_rsp_addr  = r_res_addr;
                    n_rsp_blk   = r_res_blk;
                    n_rsp_stat  = r_res_stat;
                    n_state     = sca_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sca_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sca_pkg::S_IDLE;
            r_total_cfg <= 7'd64;
            r_res_cfg   <= 6'd1;
            r_top       <= '0;
            r_next      <= 7'd1;
            r_rsp_valid <= 1'b0;
            for (int c = 0; c < sca_pkg::NUM_CLASSES; c++) begin
                r_map[c] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_next      <= n_next;
            r_rsp_valid <= n_rsp_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sca_pkg::CFG_TOTAL_BLOCKS:    r_total_cfg <= i_cfg_data;
                    sca_pkg::CFG_RESERVED_BLOCKS: r_res_cfg   <= i_cfg_data[BW-1:0];
                    default: ;
                endcase
            end
            if (map_we) begin
                r_map[map_ci][map_b] <= map_on;
            end
        end
        r_kind     <= n_kind;
        r_size     <= n_size;
        r_addr     <= n_addr;
        r_put      <= n_put;
        r_cls      <= n_cls;
        r_ci       <= n_ci;
        r_blk      <= n_blk;
        r_head     <= n_head;
        r_cnt      <= n_cnt;
        r_mode     <= n_mode;
        r_idx      <= n_idx;
        r_total    <= n_total;
        r_bytes    <= n_bytes;
        r_chunk    <= n_chunk;
        r_res_addr <= n_res_addr;
        r_res_blk  <= n_res_blk;
        r_res_stat <= n_res_stat;
        r_rsp_addr <= n_rsp_addr;
        r_rsp_blk  <= n_rsp_blk;
        r_rsp_stat <= n_rsp_stat;
    end

    assign o_rsp.valid           = r_rsp_valid;
    assign o_rsp.granted_address = r_rsp_addr;
    assign o_rsp.granted_block   = r_rsp_blk;
    assign o_rsp.status          = r_rsp_stat;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_accept |=> !i_req.ready)
        else $error("request taken while busy");

    a_bump_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next <= 7'(sca_pkg::NUM_BLOCKS + 1))
        else $error("bump pointer out of range");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_ctl.start |-> !div_sts.busy)
        else $error("divider started while busy");

    a_rsp_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sca_pkg::S_DONE && r_rsp_valid && !o_rsp.ready) |=>
        (r_state == sca_pkg::S_DONE))
        else $error("result dropped while output stalled");
`endif

endmodule
